// ===== hw/rtl/ptcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcc_pkg: shared types and constants for the photon time cluster counter
// Field widths, command codes and the control/carry structures that the
// controller broadcasts to and ripples through the row of table cells.
// ----------------------------------------------------------------------------
package ptcc_pkg;

	// field widths
	localparam int TIME_W  = 48;
	localparam int CNT_W   = 32;
	localparam int WIN_W   = 20;
	localparam int CMD_W   = 2;
	localparam int ENT_W   = 9;
	// query bounds: 48-bit time widened by the window, signed
	localparam int BOUND_W = TIME_W + 2;

	localparam int                 TABLE_DEPTH_DEFAULT = 256;
	localparam logic [WIN_W-1:0]   WIN_RESET           = WIN_W'(1000);
	localparam logic [CNT_W-1:0]   CNT_MAX             = '1;

	// command codes; code 3 is unused: it leaves the table unchanged and posts a zero count
	typedef enum logic [CMD_W-1:0] {
		CMD_RECORD = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                       flush;   // zero the carry chain
		logic                       commit;  // apply the table update
		logic                       miss;    // record found no matching entry
		cmd_t                       cmd;
		logic [TIME_W-1:0]          ptime;
		logic signed [BOUND_W-1:0]  lo;
		logic signed [BOUND_W-1:0]  hi;
		logic [WIN_W-1:0]           win;
	} ctrl_t;

	// handed from cell to cell
	typedef struct packed {
		logic             found;  // some earlier entry matched the record time
		logic [CNT_W-1:0] sum;    // saturated query sum so far
	} carry_t;

endpackage

// ===== hw/rtl/ptcc_cell.sv =====
// ----------------------------------------------------------------------------
// ptcc_cell: one table entry of the photon time cluster counter
// Holds one arrival time and its count, compares against the broadcast
// command and hands a registered found flag and partial sum to its neighbor.
// ----------------------------------------------------------------------------
module ptcc_cell
	import ptcc_pkg::*;
#(
	parameter int INDEX  = 0,
	parameter int USED_W = 9
) (
	input  logic              clk,
	input  ctrl_t             ctrl,
	input  logic [USED_W-1:0] used,
	input  carry_t            carry_in,
	output carry_t            carry_out
);

	logic [TIME_W-1:0] time_q;
	logic [CNT_W-1:0]  count_q;
	carry_t            carry_q;

	logic                       in_use;
	logic                       is_tail;
	logic [TIME_W-1:0]          diff;
	logic                       match;
	logic signed [BOUND_W-1:0]  time_s;
	logic                       in_range;
	logic [CNT_W:0]             sum_wide;
	carry_t                     carry_d;

	assign in_use  = USED_W'(INDEX) < used;
	assign is_tail = USED_W'(INDEX) == used;

	// coincidence test: |t - entry| < window
	assign diff  = (ctrl.ptime >= time_q) ? (ctrl.ptime - time_q) : (time_q - ctrl.ptime);
	assign match = in_use && (diff < {{(TIME_W-WIN_W){1'b0}}, ctrl.win});

	// query range test, strict on both ends
	assign time_s   = signed'({2'b00, time_q});
	assign in_range = in_use && (time_s > ctrl.lo) && (time_s < ctrl.hi);

	// next carry: found flag for record, saturated sum for query
	always_comb begin
		sum_wide      = {1'b0, carry_in.sum} + {1'b0, count_q};
		carry_d.found = carry_in.found | match;
		if (!in_range) begin
			carry_d.sum = carry_in.sum;
		end else if (sum_wide[CNT_W]) begin
			carry_d.sum = CNT_MAX;
		end else begin
			carry_d.sum = sum_wide[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.flush) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	// entry update: first match counts up, or the tail cell takes a new time
	always_ff @(posedge clk) begin
		if (ctrl.commit && ctrl.cmd == CMD_RECORD) begin
			if (match && !carry_in.found) begin
				if (count_q != CNT_MAX) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (is_tail && ctrl.miss) begin
				time_q  <= ctrl.ptime;
				count_q <= CNT_W'(1);
			end
		end
	end

	assign carry_out = carry_q;

endmodule

// ===== hw/rtl/photon_time_cluster_counter_top.sv =====
// ----------------------------------------------------------------------------
// photon_time_cluster_counter_top: photon arrival-time cluster table
// Record, query and clear commands over a row of TABLE_DEPTH entry cells.
// ----------------------------------------------------------------------------
// One word at a time. A record or query word is compared in every cell at
// once, then the found flag and the partial sum ripple down the row of cells
// one cell per clock; the result is posted once the ripple has reached the
// end of the row, and only then is the next word taken. Clear and the unused
// code skip the ripple and go straight to the commit state.
// The output register holds a result until the sink takes it; a new word is
// accepted meanwhile and its table update waits only if that result is still
// unread when the new one is ready. The window register resets to 1000 ns and
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module photon_time_cluster_counter_top
	import ptcc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	// input words
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [143:0]  s_axis_tdata,   // photon_time, window_start, window_end
	input  logic [1:0]    s_axis_tuser,   // command
	// result words
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [47:0]   m_axis_tdata,   // photon_count, dropped, entries_used, zero pad
	// window register
	input  logic          cfg_we,
	input  logic [19:0]   cfg_wdata
);

	localparam int USED_W = $clog2(TABLE_DEPTH + 1);
	localparam int RUN_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COMMIT
	} state_t;

	state_t                     state_q;
	logic [RUN_W-1:0]           run_q;
	logic [USED_W-1:0]          used_q;
	logic [WIN_W-1:0]           win_q;
	cmd_t                       cmd_q;
	logic [TIME_W-1:0]          ptime_q;
	logic signed [BOUND_W-1:0]  lo_q;
	logic signed [BOUND_W-1:0]  hi_q;
	logic                       out_valid_q;
	logic [CNT_W-1:0]           count_out_q;
	logic                       drop_out_q;
	logic [ENT_W-1:0]           ent_out_q;

	logic                       s_accept;
	logic                       do_commit;
	cmd_t                       in_cmd;
	logic [TIME_W-1:0]          in_ptime;
	logic [TIME_W-1:0]          in_start;
	logic [TIME_W-1:0]          in_end;
	ctrl_t                      ctrl;
	carry_t                     chain [TABLE_DEPTH+1];
	logic                       miss;
	logic                       full;
	logic [USED_W-1:0]          used_next;
	logic [USED_W+ENT_W-1:0]    used_ext;
	logic [CNT_W-1:0]           count_next;
	logic                       drop_next;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_ptime = s_axis_tdata[47:0];
	assign in_start = s_axis_tdata[95:48];
	assign in_end   = s_axis_tdata[143:96];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign do_commit     = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	// command capture, query bounds formed once per word
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q   <= in_cmd;
			ptime_q <= in_ptime;
			lo_q    <= signed'({2'b00, in_start}) - signed'({{(BOUND_W-WIN_W){1'b0}}, win_q});
			hi_q    <= signed'({2'b00, in_end}) + signed'({{(BOUND_W-WIN_W){1'b0}}, win_q});
		end
	end

	// broadcast to the cells
	always_comb begin
		ctrl.flush  = s_accept;
		ctrl.commit = do_commit;
		ctrl.miss   = miss;
		ctrl.cmd    = cmd_q;
		ctrl.ptime  = ptime_q;
		ctrl.lo     = lo_q;
		ctrl.hi     = hi_q;
		ctrl.win    = win_q;
	end

	// row of entry cells
	assign chain[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ptcc_cell #(
			.INDEX  (i),
			.USED_W (USED_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.used      (used_q),
			.carry_in  (chain[i]),
			.carry_out (chain[i+1])
		);
	end

	// result of the finished ripple
	assign miss = !chain[TABLE_DEPTH].found;
	assign full = (used_q == USED_W'(TABLE_DEPTH));

	always_comb begin
		used_next  = used_q;
		count_next = '0;
		drop_next  = 1'b0;
		unique case (cmd_q)
			CMD_RECORD: begin
				if (miss && !full) begin
					used_next = used_q + USED_W'(1);
				end
				drop_next = miss && full;
			end
			CMD_QUERY: begin
				count_next = chain[TABLE_DEPTH].sum;
			end
			CMD_CLEAR: begin
				used_next = '0;
			end
			default: begin
			end
		endcase
	end

	assign used_ext = {{ENT_W{1'b0}}, used_next};

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			count_out_q <= '0;
			drop_out_q  <= 1'b0;
			ent_out_q   <= '0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						run_q <= RUN_W'(TABLE_DEPTH - 1);
						if (in_cmd == CMD_RECORD || in_cmd == CMD_QUERY) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_RUN: begin
					run_q <= run_q - RUN_W'(1);
					if (run_q == '0) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (do_commit) begin
						used_q      <= used_next;
						out_valid_q <= 1'b1;
						count_out_q <= count_next;
						drop_out_q  <= drop_next;
						ent_out_q   <= used_ext[ENT_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, ent_out_q, drop_out_q, count_out_q};

	// the fill never passes the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("fill count beyond table size");

	// an update never overwrites an unread result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |-> (!out_valid_q || m_axis_tready))
		else $error("commit while result unread");

	// every commit posts a result
	a_commit_posts: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |=> out_valid_q)
		else $error("commit posted no result");

	// a drop is only reported with the table full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && drop_out_q) |-> full)
		else $error("drop reported with table not full");

	// no word is taken while the ripple runs
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !s_axis_tready && !do_commit)
		else $error("input or commit during ripple");

endmodule
